### src/fhp_pkg.sv
package fhp_pkg;

  localparam int FEAT_W = 16;
  localparam int DIM_W = 5;
  localparam int OUT_W = 24;
  localparam int POLE_W = 15;

  localparam int NUM_DIMS_DEFAULT = 32;
  localparam logic [POLE_W-1:0] POLE_RESET = POLE_W'(31785);

  // product of the pole and the last output, and the rounding offset for q15
  localparam int PROD_W = POLE_W + 1 + OUT_W;
  localparam int FRAC_SHIFT = 15;
  localparam int ROUND_HALF = 16384;
  localparam int FB_W = PROD_W - FRAC_SHIFT;
  localparam int ACC_W = FB_W + 1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature;
    logic [DIM_W-1:0]         dim_index;
    logic                     first_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic [DIM_W-1:0]        dim_out;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] last_input;
    logic signed [OUT_W-1:0]  last_output;
  } hist_t;

endpackage

### src/fhp_hist.sv
module fhp_hist import fhp_pkg::*; #(
  parameter int NUM_DIMS = NUM_DIMS_DEFAULT,
  localparam int AW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output hist_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  hist_t         wr_data
);

  hist_t mem [NUM_DIMS];
  logic [NUM_DIMS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // an entry never written since reset reads as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // bypass the write of the same cycle so back-to-back items of one dimension chain
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

### src/feature_highpass_filter.sv
// Per-dimension first-order high-pass filter for feature frames:
// y = x - x_prev + pole * y_prev, one filter state per dimension.
// Input channel: in_valid / in_stall / in_data carries one element (feature,
// dim_index, first_frame). Output channel: out_valid / out_stall / out_data
// carries the filtered element, the echoed dimension and a saturation flag.
// An item is taken at a clock edge with valid high and stall low.
// The user must write the pole (q15) through cfg_wr_en / cfg_wr_data only while
// idle; the block does not enforce it. Items pass the working stage, then out_data.
// Throughput: one item per cycle while out_stall is low, also for runs of one
// dimension; the history memory read is registered and the write of the item
// ahead is bypassed, so the multiply, add and clip sit in one stage.
// When out_stall holds the result register, one more item is still taken into
// the working stage; after that in_stall rises until the result drains.
// Synchronous reset sets the pole to 31785 and clears all histories at once
// (per-entry valid bits), so an item can be sent on the first cycle after rst.
// A first-frame item passes through and seeds its dimension's history; an
// item whose dimension is at or above NUM_DIMS passes through untouched.
module feature_highpass_filter import fhp_pkg::*; #(
  parameter int NUM_DIMS = NUM_DIMS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [POLE_W-1:0] cfg_wr_data
);

  localparam int AW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

  logic [POLE_W-1:0] pole;
  logic              work_valid;
  in_item_t          work;
  hist_t             hist;

  logic in_accept;
  logic work_adv;
  logic in_range;
  hist_t hist_wr;

  logic signed [POLE_W:0]   pole_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [FB_W-1:0]   fb;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OUT_W-1:0]  feat_ext;
  logic signed [OUT_W-1:0]  y;
  logic                     sat;
  out_item_t                result;

  assign work_adv  = work_valid && (!out_valid || !out_stall);
  assign in_stall  = work_valid && !work_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole <= POLE_RESET;
    end else if (cfg_wr_en) begin
      pole <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (in_accept) begin
      work_valid <= 1'b1;
    end else if (work_adv) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      work <= in_data;
    end
  end

  fhp_hist #(
    .NUM_DIMS(NUM_DIMS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (AW'(in_data.dim_index)),
    .rd_data (hist),
    .wr_en   (work_adv && in_range),
    .wr_addr (AW'(work.dim_index)),
    .wr_data (hist_wr)
  );

  assign in_range = 32'(work.dim_index) < NUM_DIMS;

  // feedback term rounded to nearest, ties toward plus infinity
  assign pole_s   = signed'({1'b0, pole});
  assign prod     = pole_s * hist.last_output;
  assign prod_rnd = prod + PROD_W'(ROUND_HALF);
  assign fb       = prod_rnd[PROD_W-1:FRAC_SHIFT];
  assign acc      = ACC_W'(work.feature) - ACC_W'(hist.last_input) + ACC_W'(fb);
  assign feat_ext = OUT_W'(work.feature);

  always_comb begin
    y   = feat_ext;
    sat = 1'b0;
    if (in_range && !work.first_frame) begin
      if ((&acc[ACC_W-1:OUT_W-1]) || !(|acc[ACC_W-1:OUT_W-1])) begin
        y = acc[OUT_W-1:0];
      end else begin
        y   = acc[ACC_W-1] ? OUT_MIN : OUT_MAX;
        sat = 1'b1;
      end
    end
  end

  always_comb begin
    hist_wr.last_input  = work.feature;
    hist_wr.last_output = y;
    result.filtered     = y;
    result.dim_out      = work.dim_index;
    result.saturated    = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_adv) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.filtered == OUT_MAX) || (out_data.filtered == OUT_MIN))
    else $error("saturated result not at a range limit");

  a_first_passes: assert property (@(posedge clk) disable iff (rst)
    work_adv && work.first_frame |=>
      !out_data.saturated && (out_data.filtered == $past(feat_ext)))
    else $error("first frame item not passed through");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !work_valid |-> !in_stall)
    else $error("input stalled with an empty working stage");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result lost or changed");
`endif

endmodule
